@@ hw/rtl/msort_pkg.sv @@
// package for the merge sorter: default sizes, status codes, request modes and the
// controller/datapath command and status structs; no dependencies
`default_nettype none

package msort_pkg;

    // default sizes
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_EMPTY    = 2'd1;
    localparam t_status STATUS_OVERFLOW = 2'd2;

    // request modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // store one value of the data set
        logic fetch;       // take the next sorted value
        logic sort_init;   // start the merge passes
        logic run_init;    // set up the bounds of the next run pair
        logic merge_step;  // move one element into the destination store
        logic push;        // move the pending result into the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic load_result; // the load being accepted produces a result
        logic sort_done;   // run width has reached the item count
        logic run_end;     // the current merge step finishes its run pair
        logic out_free;    // output register can take a result this cycle
    } t_stat;

endpackage

`default_nettype wire

@@ hw/rtl/msort_if.sv @@
// request and result channel interfaces for the merge sorter
// depends on msort_pkg for the default value width and status type
`default_nettype none

interface msort_in_if #(
    parameter int VALUE_BITS = msort_pkg::VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_item;

    modport source (output valid, output mode, output value, output last_item, input ready);
    modport sink   (input valid, input mode, input value, input last_item, output ready);
endinterface

interface msort_out_if #(
    parameter int VALUE_BITS = msort_pkg::VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sorted_value;
    logic                         final_res;
    msort_pkg::t_status           status;

    modport source (output valid, output sorted_value, output final_res, output status,
                    input ready);
    modport sink   (input valid, input sorted_value, input final_res, input status,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/merge_sorter_unit.sv @@
// top level of the merge sorter: controller and datapath on two channels
// depends on msort_pkg, msort_if, msort_ctrl and msort_dp
//
//   channel  | dir | payload                              | request
//   i_req    | in  | mode, value, last_item               | load or fetch
//   o_res    | out | sorted_value, final_res, status      | one result
//
// a plain load is taken in IDLE; a fetch or a result-bearing load also passes PUSH
// the set closes with a bottom-up merge sort over one read-pair per element,
// with a CHK state per run pair, paced by the RD/WR read/compare/write loop
// through the stores
// reset is synchronous and clears control only; the stores need no clearing
// the output register holds a result while o_res is stalled; no new request is
// taken until a pending result has moved into it
`default_nettype none

module merge_sorter_unit #(
    parameter int CAPACITY   = msort_pkg::CAPACITY,
    parameter int VALUE_BITS = msort_pkg::VALUE_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    msort_in_if.sink    i_req,
    msort_out_if.source o_res
);

    msort_pkg::t_cmd       cmd;
    msort_pkg::t_stat      stat;
    logic [VALUE_BITS-1:0] out_value;

    // controller
    msort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .i_req_last  (i_req.last_item),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath
    msort_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_value      (i_req.value),
        .i_last       (i_req.last_item),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_out_value  (out_value),
        .o_out_final  (o_res.final_res),
        .o_out_status (o_res.status)
    );

    assign o_res.sorted_value = $signed(out_value);

endmodule

`default_nettype wire

@@ hw/rtl/msort_ctrl.sv @@
// controller state machine of the merge sorter: request acceptance,
// merge pass sequencing and result hand-off; depends on msort_pkg
`default_nettype none

module msort_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire logic              i_req_mode,
    input  wire logic              i_req_last,
    output logic                   o_req_ready,
    input  wire msort_pkg::t_stat  i_stat,
    output msort_pkg::t_cmd        o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_push_after, n_push_after;
    logic       accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_push_after = r_push_after;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_mode == msort_pkg::MODE_LOAD) begin
                        o_cmd.load = 1'b1;
                        if (i_req_last) begin
                            o_cmd.sort_init = 1'b1;
                            n_push_after    = i_stat.load_result;
                            n_state         = S_CHK;
                        end else if (i_stat.load_result) begin
                            n_state = S_PUSH;
                        end
                    end else begin
                        o_cmd.fetch = 1'b1;
                        n_state     = S_PUSH;
                    end
                end
            end
            S_CHK: begin
                if (i_stat.sort_done) begin
                    n_state = r_push_after ? S_PUSH : S_IDLE;
                end else begin
                    o_cmd.run_init = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.merge_step = 1'b1;
                n_state          = i_stat.run_end ? S_CHK : S_RD;
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_push_after <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_push_after <= n_push_after;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/msort_dp.sv @@
// datapath of the merge sorter: value and scratch stores, set bookkeeping,
// merge pointers and comparator, output register; depends on msort_pkg
`default_nettype none

module msort_dp #(
    parameter int CAPACITY   = msort_pkg::CAPACITY,
    parameter int VALUE_BITS = msort_pkg::VALUE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire msort_pkg::t_cmd        i_cmd,
    output msort_pkg::t_stat            o_stat,
    input  wire logic [VALUE_BITS-1:0]  i_value,
    input  wire logic                   i_last,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [VALUE_BITS-1:0]       o_out_value,
    output logic                        o_out_final,
    output msort_pkg::t_status          o_out_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    // stores
    logic [VALUE_BITS-1:0] r_vmem [CAPACITY];
    logic [VALUE_BITS-1:0] r_smem [CAPACITY];
    logic [VALUE_BITS-1:0] r_va, r_vb, r_sa, r_sb;

    // set bookkeeping
    logic [CW-1:0] r_count, r_rp;
    logic          r_ovf, r_sorted;

    // merge state
    logic          r_src;
    logic [CW:0]   r_w;
    logic [CW-1:0] r_lo, r_l, r_r, r_k, r_mid, r_hi;

    // pending result and output register
    logic                  r_pend_ok, r_pend_final;
    msort_pkg::t_status    r_pend_status;
    logic                  r_fetch_hold;
    logic                  r_out_valid, r_out_final;
    logic [VALUE_BITS-1:0] r_out_value;
    msort_pkg::t_status    r_out_status;

    logic [CW-1:0]         eff_cnt;
    logic                  eff_ovf, load_fits, ovf_new;
    logic                  fetch_ok;
    logic [AW-1:0]         addr_a, addr_b, waddr_v, waddr_s;
    logic                  we_v, we_s;
    logic [VALUE_BITS-1:0] wdata_v, src_a, src_b, res_a;
    logic                  left_ok, right_ok, take_left;
    logic [CW-1:0]         k_next;
    logic [SW-1:0]         s_mid, s_hi, s_lo, s_n;

    // load bookkeeping
    assign eff_cnt   = r_sorted ? '0 : r_count;
    assign eff_ovf   = r_sorted ? 1'b0 : r_ovf;
    assign load_fits = (eff_cnt < CAP);
    assign ovf_new   = eff_ovf || !load_fits;
    assign fetch_ok  = r_sorted && (r_rp < r_count);

    // merge compare on the registered read data of the source store
    assign src_a     = r_src ? r_sa : r_va;
    assign src_b     = r_src ? r_sb : r_vb;
    assign res_a     = r_src ? r_sa : r_va;
    assign left_ok   = (r_l < r_mid);
    assign right_ok  = (r_r < r_hi);
    assign take_left = left_ok && (!right_ok || ($signed(src_a) <= $signed(src_b)));
    assign k_next    = r_k + CW'(1);

    // run bounds and pass advance
    assign s_n   = SW'(r_count);
    assign s_mid = SW'(r_lo) + SW'(r_w);
    assign s_hi  = SW'(r_lo) + (SW'(r_w) << 1);
    assign s_lo  = s_hi;

    // status to controller
    assign o_stat.load_result = !load_fits || (i_last && ovf_new);
    assign o_stat.sort_done   = (r_w >= (CW + 1)'(r_count));
    assign o_stat.run_end     = (k_next == r_hi);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // memory ports
    assign addr_a  = i_cmd.fetch ? r_rp[AW-1:0] : r_l[AW-1:0];
    assign addr_b  = r_r[AW-1:0];
    assign we_v    = (i_cmd.load && load_fits) || (i_cmd.merge_step && r_src);
    assign waddr_v = i_cmd.load ? eff_cnt[AW-1:0] : r_k[AW-1:0];
    assign wdata_v = i_cmd.load ? i_value : (take_left ? src_a : src_b);
    assign we_s    = i_cmd.merge_step && !r_src;
    assign waddr_s = r_k[AW-1:0];

    // value store; read data is held while a fetched word waits for the output
    always_ff @(posedge i_clk) begin
        if (we_v) begin
            r_vmem[waddr_v] <= wdata_v;
        end
        if (!r_fetch_hold) begin
            r_va <= r_vmem[addr_a];
            r_vb <= r_vmem[addr_b];
        end
    end

    // scratch store
    always_ff @(posedge i_clk) begin
        if (we_s) begin
            r_smem[waddr_s] <= take_left ? src_a : src_b;
        end
        if (!r_fetch_hold) begin
            r_sa <= r_smem[addr_a];
            r_sb <= r_smem[addr_b];
        end
    end

    // set bookkeeping and merge pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_rp         <= '0;
            r_ovf        <= 1'b0;
            r_sorted     <= 1'b0;
            r_src        <= 1'b0;
            r_w          <= '0;
            r_lo         <= '0;
            r_fetch_hold <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count  <= load_fits ? eff_cnt + CW'(1) : eff_cnt;
                r_ovf    <= ovf_new;
                r_sorted <= i_last;
                r_rp     <= '0;
            end
            if (i_cmd.fetch && fetch_ok) begin
                r_rp <= r_rp + CW'(1);
            end
            // fetched word stays in the read registers until pushed
            if (i_cmd.fetch) begin
                r_fetch_hold <= 1'b1;
            end else if (i_cmd.push) begin
                r_fetch_hold <= 1'b0;
            end
            if (i_cmd.sort_init) begin
                r_w   <= (CW + 1)'(1);
                r_lo  <= '0;
                r_src <= 1'b0;
            end
            if (i_cmd.merge_step && (k_next == r_hi)) begin
                if (s_lo >= s_n) begin
                    r_lo  <= '0;
                    r_w   <= r_w << 1;
                    r_src <= !r_src;
                end else begin
                    r_lo <= s_lo[CW-1:0];
                end
            end
        end
    end

    // element pointers of the current run pair
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_l   <= r_lo;
            r_k   <= r_lo;
            r_mid <= (s_mid < s_n) ? s_mid[CW-1:0] : r_count;
            r_r   <= (s_mid < s_n) ? s_mid[CW-1:0] : r_count;
            r_hi  <= (s_hi < s_n) ? s_hi[CW-1:0] : r_count;
        end else if (i_cmd.merge_step) begin
            r_k <= k_next;
            if (take_left) begin
                r_l <= r_l + CW'(1);
            end else begin
                r_r <= r_r + CW'(1);
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pend_ok     <= 1'b0;
            r_pend_final  <= 1'b0;
            r_pend_status <= msort_pkg::STATUS_OVERFLOW;
        end else if (i_cmd.fetch) begin
            r_pend_ok     <= fetch_ok;
            r_pend_final  <= fetch_ok && ((r_rp + CW'(1)) == r_count);
            r_pend_status <= fetch_ok ? msort_pkg::STATUS_OK : msort_pkg::STATUS_EMPTY;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_value  <= r_pend_ok ? res_a : '0;
            r_out_final  <= r_pend_final;
            r_out_status <= r_pend_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_final  = r_out_final;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for merge_sorter_unit: directed table, then random data sets
// depends on msort_pkg, msort_if and the merge_sorter_unit rtl
`default_nettype none

module testbench;
    import msort_pkg::*;

    localparam int REQUEST_TARGET = 1550;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DIRECTED_COUNT = 25;

    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum logic {SET_LOADING, SET_SORTED} set_phase_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] sorted_value;
        logic                         final_res;
        t_status                      status;
    } sorter_result_t;

    typedef struct packed {
        logic                         mode;
        logic signed [VALUE_BITS-1:0] value;
        logic                         last_item;
        logic                         fixed_want;
        logic signed [VALUE_BITS-1:0] want_value;
        logic                         want_final;
        t_status                      want_status;
    } request_row_t;

    // directed table: fixed results only where they are obvious
    localparam request_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{MODE_FETCH, 0,         1'b0, 1'b1, 0,         1'b0, STATUS_EMPTY},
        '{MODE_LOAD,  VALUE_MIN, 1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_LOAD,  VALUE_MAX, 1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_LOAD,  0,         1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_LOAD,  -1,        1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 0,         1'b0, STATUS_EMPTY},
        '{MODE_LOAD,  1,         1'b1, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, VALUE_MIN, 1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 1,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, VALUE_MAX, 1'b1, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 0,         1'b0, STATUS_EMPTY},
        '{MODE_LOAD,  5,         1'b1, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 5,         1'b1, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 0,         1'b0, STATUS_EMPTY},
        '{MODE_LOAD,  7,         1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_LOAD,  7,         1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_LOAD,  -7,        1'b1, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, -7,        1'b0, STATUS_OK},
        '{MODE_LOAD,  3,         1'b0, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_LOAD,  3,         1'b1, 1'b0, 0,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 3,         1'b0, STATUS_OK},
        '{MODE_FETCH, 0,         1'b0, 1'b1, 3,         1'b1, STATUS_OK},
        '{MODE_FETCH, -1,        1'b1, 1'b1, 0,         1'b0, STATUS_EMPTY}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    msort_in_if  #(.VALUE_BITS(VALUE_BITS)) req_chan ();
    msort_out_if #(.VALUE_BITS(VALUE_BITS)) res_chan ();

    merge_sorter_unit #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_chan.sink),
        .o_res   (res_chan.source)
    );

    // mirror of the sorter state
    logic signed [VALUE_BITS-1:0] sorted_store [CAPACITY];
    int         stored_count = 0;
    int         read_index   = 0;
    set_phase_t set_phase    = SET_LOADING;
    bit         set_dropped  = 1'b0;

    sorter_result_t responses_due [$];

    int  requests_sent  = 0;
    int  results_seen   = 0;
    int  sets_closed    = 0;
    int  empty_count    = 0;
    int  overflow_count = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  calm_stretch   = 1'b0;
    bit  hold_request   = 1'b0;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // response of the sorter to one accepted request, state updated in place
    function automatic bit sorter_response(input logic mode,
                                           input logic signed [VALUE_BITS-1:0] value,
                                           input logic last_item,
                                           output sorter_result_t resp);
        bit dropped;
        int i;
        int j;
        logic signed [VALUE_BITS-1:0] key;
        resp.sorted_value = '0;
        resp.final_res    = 1'b0;
        resp.status       = STATUS_EMPTY;
        dropped           = 1'b0;
        if (mode == MODE_LOAD) begin
            // a load after a sorted set opens a new set
            if (set_phase != SET_LOADING) begin
                stored_count = 0;
                read_index   = 0;
                set_dropped  = 1'b0;
                set_phase    = SET_LOADING;
            end
            if (stored_count < CAPACITY) begin
                sorted_store[stored_count] = value;
                stored_count++;
            end else begin
                set_dropped = 1'b1;
                dropped     = 1'b1;
            end
            // closing the set: stable ascending sort
            if (last_item) begin
                for (i = 1; i < stored_count; i++) begin
                    key = sorted_store[i];
                    j   = i - 1;
                    while (j >= 0 && sorted_store[j] > key) begin
                        sorted_store[j+1] = sorted_store[j];
                        j--;
                    end
                    sorted_store[j+1] = key;
                end
                read_index = 0;
                set_phase  = SET_SORTED;
                sets_closed++;
            end
            if (dropped || (last_item && set_dropped)) begin
                resp.status = STATUS_OVERFLOW;
                overflow_count++;
                return 1'b1;
            end
            return 1'b0;
        end
        // fetch while loading or past the end
        if (set_phase != SET_SORTED || read_index >= stored_count) begin
            empty_count++;
            return 1'b1;
        end
        resp.sorted_value = sorted_store[read_index];
        resp.final_res    = (read_index + 1 == stored_count);
        resp.status       = STATUS_OK;
        read_index++;
        return 1'b1;
    endfunction

    // values biased toward extremes and ties
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(3))
                0: return VALUE_MIN;
                1: return VALUE_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        if (pick < 40)
            return $signed($urandom_range(16)) - 8;
        return $urandom;
    endfunction

    // offer one request and wait for it to be taken
    task automatic offer_request(input logic mode, input logic signed [VALUE_BITS-1:0] value,
                                 input logic last_item, input bit fixed_want,
                                 input sorter_result_t want);
        sorter_result_t resp;
        bit             has_resp;
        if (!calm_stretch && $urandom_range(99) < 19) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_chan.valid     <= 1'b1;
        req_chan.mode      <= mode;
        req_chan.value     <= value;
        req_chan.last_item <= last_item;
        do @(posedge i_clk); while (req_chan.ready !== 1'b1);
        has_resp = sorter_response(mode, value, last_item, resp);
        if (fixed_want)
            responses_due.push_back(want);
        else if (has_resp)
            responses_due.push_back(resp);
        requests_sent++;
    endtask

    // result side: check each taken result, random stalls and one long hold-off
    initial begin
        sorter_result_t want;
        int             hold_left;
        hold_left = 0;
        res_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_chan.valid === 1'b1 && res_chan.ready === 1'b1) begin
                results_seen++;
                if (responses_due.size() == 0) begin
                    $error("result with nothing due: sorted_value %0d final_res %0b status %0d",
                           res_chan.sorted_value, res_chan.final_res, res_chan.status);
                    mismatch_count++;
                end else begin
                    want = responses_due.pop_front();
                    if (res_chan.sorted_value !== want.sorted_value) begin
                        $error("sorted_value: expected %0d, got %0d",
                               want.sorted_value, res_chan.sorted_value);
                        mismatch_count++;
                    end
                    if (res_chan.final_res !== want.final_res) begin
                        $error("final_res: expected %0b, got %0b",
                               want.final_res, res_chan.final_res);
                        mismatch_count++;
                    end
                    if (res_chan.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_chan.status);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                res_chan.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                res_chan.ready <= 1'b0;
            end else begin
                res_chan.ready <= calm_stretch || ($urandom_range(99) >= 19);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("merge_sorter_unit regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        sorter_result_t want;
        request_row_t   row;
        int             set_size;
        int             fetch_total;
        int             pick;
        bit             close_set;
        bit             capacity_done;
        bit             hold_done;
        bit             pause_done;

        capacity_done = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        i_rst_n            <= 1'b0;
        req_chan.valid     <= 1'b0;
        req_chan.mode      <= MODE_LOAD;
        req_chan.value     <= '0;
        req_chan.last_item <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            row               = DIRECTED_ROWS[r];
            want.sorted_value = row.want_value;
            want.final_res    = row.want_final;
            want.status       = row.want_status;
            offer_request(row.mode, row.value, row.last_item, row.fixed_want, want);
        end

        // random data sets
        want = '0;
        while (requests_sent < REQUEST_TARGET) begin
            // tail of the run goes without any idling
            calm_stretch = (requests_sent >= 1400);
            if (!capacity_done && requests_sent >= 300) begin
                // one set past capacity: the last three loads are dropped
                for (int i = 0; i < CAPACITY + 3; i++)
                    offer_request(MODE_LOAD, pick_value(), i == CAPACITY + 2, 1'b0, want);
                for (int i = 0; i < 24; i++)
                    offer_request(MODE_FETCH, $urandom, 1'($urandom_range(1)), 1'b0, want);
                capacity_done = 1'b1;
            end else begin
                pick      = $urandom_range(99);
                set_size  = (pick < 90) ? $urandom_range(1, 16) : $urandom_range(17, 64);
                close_set = ($urandom_range(99) >= 8);
                for (int i = 0; i < set_size; i++) begin
                    // stray fetch in the middle of loading
                    if ($urandom_range(99) < 4)
                        offer_request(MODE_FETCH, $urandom, 1'($urandom_range(1)), 1'b0,
                                      want);
                    offer_request(MODE_LOAD, pick_value(), close_set && i == set_size - 1,
                                  1'b0, want);
                end
                if (close_set) begin
                    pick = $urandom_range(99);
                    if (pick < 75)
                        fetch_total = set_size;
                    else if (pick < 90)
                        fetch_total = set_size + $urandom_range(1, 2);
                    else
                        fetch_total = $urandom_range(set_size - 1);
                    // long result stall while fetches keep coming
                    if (!hold_done && requests_sent >= 150 && set_size >= 4) begin
                        hold_done    = 1'b1;
                        hold_request = 1'b1;
                        fetch_total  = set_size + 1;
                    end
                    for (int i = 0; i < fetch_total; i++)
                        offer_request(MODE_FETCH, $urandom, 1'($urandom_range(1)), 1'b0,
                                      want);
                end
            end
            // sender waits for every result once
            if (!pause_done && requests_sent >= 900) begin
                pause_done = 1'b1;
                req_chan.valid <= 1'b0;
                do @(posedge i_clk); while (responses_due.size() != 0);
            end
        end
        calm_stretch = 1'b0;

        // drain
        req_chan.valid <= 1'b0;
        do @(posedge i_clk); while (responses_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests over %0d sorted sets, one of them past capacity",
                 requests_sent, sets_closed);
        $display("checked %0d results, %0d empty and %0d overflow",
                 results_seen, empty_count, overflow_count);
        if (mismatch_count == 0 && responses_due.size() == 0)
            $display("merge_sorter_unit regression: pass");
        else
            $display("merge_sorter_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
